// ===== rtl/sdbp_pkg.sv =====
// Shared types and constants of the sampling dead-block predictor.
package sdbp_pkg;

    localparam int TAG_W   = 64;
    localparam int ADDR_W  = 64;
    localparam int SET_IN_W = 5;
    localparam int CTR_W   = 3;
    localparam int SHIFT_W = 6;

    localparam logic [CTR_W-1:0]   CTR_MAX = 3'h7;
    localparam logic [CTR_W-1:0]   CTR_MIN = 3'h0;
    localparam logic [SHIFT_W-1:0] TAG_SHIFT_RESET = 6'd17;

    localparam int APB_ADDR_W = 3;
    localparam logic [APB_ADDR_W-1:0] REG_TAG_SHIFT = 3'h0;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVAL,
        ST_UPDATE
    } state_t;

    typedef struct packed {
        logic [CTR_W-1:0] prediction;
        logic             sampler_hit;
    } res_t;

endpackage

// ===== rtl/sdbp_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module sdbp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/sdbp_front.sv =====
// Front part: accepts accesses, forms tag, counter index and sampler set, and queues them.
module sdbp_front import sdbp_pkg::*; #(
    parameter int SAMPLER_SETS = 32,
    parameter int PRED_ENTRIES = 4096,
    localparam int SW = (SAMPLER_SETS > 1) ? $clog2(SAMPLER_SETS) : 1,
    localparam int PW = $clog2(PRED_ENTRIES),
    localparam int IW = TAG_W + PW + 1 + SW
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  logic [ADDR_W-1:0]   address,
    input  logic [ADDR_W-1:0]   program_counter,
    input  logic                set_sampled,
    input  logic [SET_IN_W-1:0] sampler_index,
    input  logic [SHIFT_W-1:0]  tag_shift,
    input  logic                busy,
    output logic                item_valid,
    output logic [IW-1:0]       item_data,
    input  logic                item_pop
);

    logic [SW-1:0] mod_tab [2**SET_IN_W];
    logic [SW-1:0] set_mod;
    logic [TAG_W-1:0] tag;
    logic [IW-1:0] item_in;
    logic [IW-1:0] slot_reg [2];
    logic wr_ptr_reg;
    logic rd_ptr_reg;
    logic [1:0] count_reg;
    logic do_push;

    for (genvar k = 0; k < 2**SET_IN_W; k++)
    begin : g_mod
        localparam int R = k % SAMPLER_SETS;
        assign mod_tab[k] = SW'(R);
    end

    assign set_mod = mod_tab[sampler_index];
    assign tag = address >> tag_shift;
    assign item_in = {tag, program_counter[PW-1:0], set_sampled, set_mod};

    assign full = (count_reg == 2'd2) || busy;
    assign do_push = push && !full;
    assign item_valid = (count_reg != 2'd0);
    assign item_data = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= item_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (item_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= 2'(count_reg + {1'b0, do_push} - {1'b0, item_pop});
        end
    end

endmodule

// ===== rtl/sdbp_back.sv =====
// Back part: sampler lookup, victim choice, LRU and counter update, result register.
module sdbp_back import sdbp_pkg::*; #(
    parameter int SAMPLER_SETS = 32,
    parameter int SAMPLER_WAYS = 16,
    parameter int PRED_ENTRIES = 4096,
    localparam int SW = (SAMPLER_SETS > 1) ? $clog2(SAMPLER_SETS) : 1,
    localparam int PW = $clog2(PRED_ENTRIES),
    localparam int IW = TAG_W + PW + 1 + SW
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          item_valid,
    input  logic [IW-1:0] item_data,
    output logic          item_pop,
    output logic          busy,
    output logic          res_valid,
    input  logic          res_pop,
    output res_t          res
);

    localparam int WW = $clog2(SAMPLER_WAYS);
    localparam int EW = 2 + TAG_W + PW + WW;
    localparam int ROW_W = SAMPLER_WAYS * EW;
    localparam int OFF_USED = 1;
    localparam int OFF_TAG = 2;
    localparam int OFF_PC = 2 + TAG_W;
    localparam int OFF_RANK = 2 + TAG_W + PW;
    localparam logic [WW-1:0] LRU_RANK = WW'(SAMPLER_WAYS - 1);

    state_t state_reg, state_next;

    logic [SW-1:0]    head_set;
    logic [PW-1:0]    head_pc;
    logic             head_sampled;
    logic [TAG_W-1:0] head_tag;

    logic [TAG_W-1:0] cur_tag_reg;
    logic [PW-1:0]    cur_pc_reg;
    logic [SW-1:0]    cur_set_reg;
    logic             cur_sampled_reg;
    logic             row_ok_reg;
    logic             set_valid_reg [SAMPLER_SETS];

    logic [ROW_W-1:0] row_rdata;
    logic [ROW_W-1:0] cur_row;
    logic [ROW_W-1:0] new_row;
    logic [ROW_W-1:0] new_row_reg;
    logic [CTR_W-1:0] ctr_rdata;
    logic [CTR_W-1:0] ctr_new;
    logic [PW-1:0]    eval_idx;
    logic             eval_hit;
    logic             eval_inc;
    logic [PW-1:0]    idx_reg;
    logic             inc_reg;
    logic             dec_reg;
    logic             hit_reg;
    logic [CTR_W-1:0] pred_reg;

    logic             clearing_reg;
    logic [PW-1:0]    clr_cnt_reg;

    logic             start;
    logic             row_we;
    logic             ctr_we;
    logic [PW-1:0]    ctr_waddr;
    logic [CTR_W-1:0] ctr_wdata;
    logic [PW-1:0]    ctr_raddr;

    logic             out_valid_reg;
    res_t             out_reg;

    assign head_set     = item_data[SW-1:0];
    assign head_sampled = item_data[SW];
    assign head_pc      = item_data[SW+PW:SW+1];
    assign head_tag     = item_data[IW-1:SW+PW+1];

    assign busy = clearing_reg;
    assign item_pop = start;
    assign res_valid = out_valid_reg;
    assign res = out_reg;

    always_comb
    begin
        cur_row = row_rdata;
        if (!row_ok_reg)
        begin
            for (int w = 0; w < SAMPLER_WAYS; w++)
            begin
                cur_row[w*EW +: EW] = {LRU_RANK, {(PW + TAG_W + 2){1'b0}}};
            end
        end
    end

    always_comb
    begin
        logic             hv;
        logic             any_inv;
        logic             any_lru;
        logic [WW-1:0]    hw;
        logic [WW-1:0]    iw;
        logic [WW-1:0]    lw;
        logic [WW-1:0]    way;
        logic [WW-1:0]    touched;
        logic [WW-1:0]    rk;
        logic [EW-1:0]    ent;
        hv = 1'b0;
        any_inv = 1'b0;
        any_lru = 1'b0;
        hw = '0;
        iw = '0;
        lw = '0;
        for (int w = SAMPLER_WAYS - 1; w >= 0; w--)
        begin
            ent = cur_row[w*EW +: EW];
            if (ent[0] && (ent[OFF_TAG +: TAG_W] == cur_tag_reg))
            begin
                hv = 1'b1;
                hw = WW'(w);
            end
            if (!ent[0])
            begin
                any_inv = 1'b1;
                iw = WW'(w);
            end
            if (ent[OFF_RANK +: WW] == LRU_RANK)
            begin
                any_lru = 1'b1;
                lw = WW'(w);
            end
        end
        if (hv)
        begin
            way = hw;
        end
        else if (any_inv)
        begin
            way = iw;
        end
        else if (any_lru)
        begin
            way = lw;
        end
        else
        begin
            way = LRU_RANK;
        end
        ent = cur_row[way*EW +: EW];
        touched = ent[OFF_RANK +: WW];
        eval_idx = ent[OFF_PC +: PW];
        eval_hit = hv;
        eval_inc = !hv && ent[0] && !ent[OFF_USED];
        new_row = cur_row;
        for (int w = 0; w < SAMPLER_WAYS; w++)
        begin
            rk = cur_row[w*EW + OFF_RANK +: WW];
            if (WW'(w) == way)
            begin
                new_row[w*EW + OFF_RANK +: WW] = '0;
                if (hv)
                begin
                    new_row[w*EW + OFF_USED] = 1'b1;
                end
                else
                begin
                    new_row[w*EW +: OFF_RANK] = {cur_pc_reg, cur_tag_reg, 1'b0, 1'b1};
                end
            end
            else if (rk < touched)
            begin
                new_row[w*EW + OFF_RANK +: WW] = WW'(rk + 1'b1);
            end
        end
    end

    always_comb
    begin
        ctr_new = ctr_rdata;
        if (inc_reg && (ctr_rdata != CTR_MAX))
        begin
            ctr_new = CTR_W'(ctr_rdata + 1'b1);
        end
        else if (dec_reg && (ctr_rdata != CTR_MIN))
        begin
            ctr_new = CTR_W'(ctr_rdata - 1'b1);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                state_next = cur_sampled_reg ? ST_UPDATE : ST_IDLE;
            end
            ST_UPDATE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        start = (state_reg == ST_IDLE) && !clearing_reg && item_valid &&
                (!out_valid_reg || res_pop);
        ctr_raddr = (state_reg == ST_IDLE) ? head_pc : eval_idx;
        row_we = (state_reg == ST_UPDATE);
        if (clearing_reg)
        begin
            ctr_we = 1'b1;
            ctr_waddr = clr_cnt_reg;
            ctr_wdata = CTR_MIN;
        end
        else
        begin
            ctr_we = (state_reg == ST_UPDATE) && (inc_reg || dec_reg);
            ctr_waddr = idx_reg;
            ctr_wdata = ctr_new;
        end
    end

    sdbp_ram #(
        .WIDTH (ROW_W),
        .DEPTH (SAMPLER_SETS)
    ) u_row_ram (
        .clk   (clk),
        .we    (row_we),
        .waddr (cur_set_reg),
        .wdata (new_row_reg),
        .raddr (head_set),
        .rdata (row_rdata)
    );

    sdbp_ram #(
        .WIDTH (CTR_W),
        .DEPTH (PRED_ENTRIES)
    ) u_ctr_ram (
        .clk   (clk),
        .we    (ctr_we),
        .waddr (ctr_waddr),
        .wdata (ctr_wdata),
        .raddr (ctr_raddr),
        .rdata (ctr_rdata)
    );

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            cur_tag_reg     <= head_tag;
            cur_pc_reg      <= head_pc;
            cur_set_reg     <= head_set;
            cur_sampled_reg <= head_sampled;
        end
        if (state_reg == ST_EVAL)
        begin
            new_row_reg <= new_row;
            idx_reg     <= eval_idx;
            inc_reg     <= eval_inc;
            dec_reg     <= eval_hit;
            hit_reg     <= eval_hit;
            pred_reg    <= ctr_rdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            clearing_reg  <= 1'b1;
            clr_cnt_reg   <= '0;
            row_ok_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
            for (int s = 0; s < SAMPLER_SETS; s++)
            begin
                set_valid_reg[s] <= 1'b0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (clearing_reg)
            begin
                clr_cnt_reg <= PW'(clr_cnt_reg + 1'b1);
                if (clr_cnt_reg == PW'(PRED_ENTRIES - 1))
                begin
                    clearing_reg <= 1'b0;
                end
            end
            if (start)
            begin
                row_ok_reg <= set_valid_reg[head_set];
            end
            if (row_we)
            begin
                set_valid_reg[cur_set_reg] <= 1'b1;
            end
            if ((state_reg == ST_EVAL) && !cur_sampled_reg)
            begin
                out_valid_reg <= 1'b1;
                out_reg <= '{prediction: ctr_rdata, sampler_hit: 1'b0};
            end
            else if (state_reg == ST_UPDATE)
            begin
                out_valid_reg <= 1'b1;
                out_reg <= '{prediction: pred_reg, sampler_hit: hit_reg};
            end
            else if (res_pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        clearing_reg |-> (state_reg == ST_IDLE) && !start)
        else $error("Access started during the counter clearing pass.");

    a_busy_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !out_valid_reg)
        else $error("Access in flight while a result is still held.");

    a_clear_zero: assert property (@(posedge clk) disable iff (!rst_n)
        clearing_reg |-> ctr_we && (ctr_wdata == CTR_MIN))
        else $error("Clearing pass wrote a nonzero counter.");

    a_update_follows_eval: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_UPDATE) |-> $past(state_reg) == ST_EVAL && cur_sampled_reg)
        else $error("Sampler update without a sampled evaluation.");

endmodule

// ===== rtl/sampling_dead_block_predictor.sv =====
// Top level of the sampling dead-block predictor: configuration register and the two parts.
// An unsampled transaction gets its result after the evaluate state, a sampled one after the
// update state; the back part starts no new transaction until the last one is done, as set by
// the read-evaluate-write sequence on the sampler row memory and the counter memory.
// Reset clears the sampler through per-set valid bits at once; the counter memory is cleared by
// a pass over all PRED_ENTRIES entries after reset, during which full stays high.
module sampling_dead_block_predictor import sdbp_pkg::*; #(
    parameter int SAMPLER_SETS = 32,
    parameter int SAMPLER_WAYS = 16,
    parameter int PRED_ENTRIES = 4096
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    output logic                  full,
    input  logic [ADDR_W-1:0]     address,
    input  logic [ADDR_W-1:0]     program_counter,
    input  logic                  set_sampled,
    input  logic [SET_IN_W-1:0]   sampler_index,
    output logic                  empty,
    input  logic                  pop,
    output logic [CTR_W-1:0]      prediction,
    output logic                  sampler_hit,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    localparam int SW = (SAMPLER_SETS > 1) ? $clog2(SAMPLER_SETS) : 1;
    localparam int PW = $clog2(PRED_ENTRIES);
    localparam int IW = TAG_W + PW + 1 + SW;

    logic [SHIFT_W-1:0] tag_shift_reg;
    logic               busy;
    logic               item_valid;
    logic [IW-1:0]      item_data;
    logic               item_pop;
    logic               res_valid;
    res_t               res;

    assign pready = 1'b1;
    assign prdata = (paddr == REG_TAG_SHIFT) ? {{(32 - SHIFT_W){1'b0}}, tag_shift_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_shift_reg <= TAG_SHIFT_RESET;
        end
        else if (psel && penable && pwrite && pready && (paddr == REG_TAG_SHIFT))
        begin
            tag_shift_reg <= pwdata[SHIFT_W-1:0];
        end
    end

    sdbp_front #(
        .SAMPLER_SETS (SAMPLER_SETS),
        .PRED_ENTRIES (PRED_ENTRIES)
    ) u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .push            (push),
        .full            (full),
        .address         (address),
        .program_counter (program_counter),
        .set_sampled     (set_sampled),
        .sampler_index   (sampler_index),
        .tag_shift       (tag_shift_reg),
        .busy            (busy),
        .item_valid      (item_valid),
        .item_data       (item_data),
        .item_pop        (item_pop)
    );

    sdbp_back #(
        .SAMPLER_SETS (SAMPLER_SETS),
        .SAMPLER_WAYS (SAMPLER_WAYS),
        .PRED_ENTRIES (PRED_ENTRIES)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_data  (item_data),
        .item_pop   (item_pop),
        .busy       (busy),
        .res_valid  (res_valid),
        .res_pop    (pop && res_valid),
        .res        (res)
    );

    assign empty = !res_valid;
    assign prediction = res.prediction;
    assign sampler_hit = res.sampler_hit;

endmodule

// ===== test/sampling_dead_block_predictor_tb.sv =====
// Self-checking testbench for the sampling dead-block predictor with a scoreboard class.
module sampling_dead_block_predictor_tb;
    import sdbp_pkg::*;

    localparam int SETS = 32;
    localparam int WAYS = 16;
    localparam int ENTRIES = 4096;

    class dead_block_scoreboard;
        bit          valid_q[SETS][WAYS];
        bit          used_q[SETS][WAYS];
        bit [63:0]   tag_q[SETS][WAYS];
        bit [11:0]   pcidx_q[SETS][WAYS];
        int unsigned rank_q[SETS][WAYS];
        bit [2:0]    counters[ENTRIES];
        bit [5:0]    shift;
        res_t        pending[$];
        int          errors;
        int          checked;
        int          hits;

        function new();
            for (int s = 0; s < SETS; s++)
                for (int w = 0; w < WAYS; w++)
                begin
                    valid_q[s][w] = 0;
                    used_q[s][w] = 0;
                    tag_q[s][w] = '0;
                    pcidx_q[s][w] = '0;
                    rank_q[s][w] = WAYS - 1;
                end
            foreach (counters[i]) counters[i] = '0;
            shift = TAG_SHIFT_RESET;
            errors = 0;
            checked = 0;
            hits = 0;
        endfunction

        function void note_access(bit [63:0] addr, bit [63:0] pc, bit smp, bit [4:0] sset);
            res_t r;
            int s;
            int way;
            int touched;
            bit hit;
            bit [63:0] tg;
            bit [11:0] idx;
            s = sset % SETS;
            tg = addr >> shift;
            hit = 0;
            way = 0;
            r.prediction = counters[pc % ENTRIES];
            r.sampler_hit = 0;
            if (smp)
            begin
                for (int w = 0; w < WAYS; w++)
                    if (!hit && valid_q[s][w] && tag_q[s][w] == tg)
                    begin
                        hit = 1;
                        way = w;
                    end
                if (hit)
                begin
                    idx = pcidx_q[s][way];
                    if (counters[idx] > CTR_MIN) counters[idx]--;
                    used_q[s][way] = 1;
                end
                else
                begin
                    way = -1;
                    for (int w = 0; w < WAYS; w++)
                        if (way < 0 && !valid_q[s][w]) way = w;
                    for (int w = 0; w < WAYS; w++)
                        if (way < 0 && rank_q[s][w] == WAYS - 1) way = w;
                    if (way < 0) way = WAYS - 1;
                    idx = pcidx_q[s][way];
                    if (valid_q[s][way] && !used_q[s][way] && counters[idx] < CTR_MAX)
                        counters[idx]++;
                    tag_q[s][way] = tg;
                    pcidx_q[s][way] = 12'(pc % ENTRIES);
                    used_q[s][way] = 0;
                    valid_q[s][way] = 1;
                end
                touched = rank_q[s][way];
                for (int w = 0; w < WAYS; w++)
                    if (rank_q[s][w] < touched) rank_q[s][w]++;
                rank_q[s][way] = 0;
                r.sampler_hit = hit;
            end
            pending.push_back(r);
        endfunction

        function void check_result(bit [2:0] pred, bit hitv);
            res_t e;
            if (pending.size() == 0)
            begin
                $error("result with no transaction outstanding: prediction %0d hit %0d",
                       pred, hitv);
                errors++;
                return;
            end
            e = pending.pop_front();
            checked++;
            if (hitv) hits++;
            if (e.prediction !== pred)
            begin
                $error("prediction: expected %0d, actual %0d", e.prediction, pred);
                errors++;
            end
            if (e.sampler_hit !== hitv)
            begin
                $error("sampler_hit: expected %0d, actual %0d", e.sampler_hit, hitv);
                errors++;
            end
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  push;
    logic                  full;
    logic [ADDR_W-1:0]     address;
    logic [ADDR_W-1:0]     program_counter;
    logic                  set_sampled;
    logic [SET_IN_W-1:0]   sampler_index;
    logic                  empty;
    logic                  pop;
    logic [CTR_W-1:0]      prediction;
    logic                  sampler_hit;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [31:0]           pwdata;
    logic [31:0]           prdata;
    logic                  pready;

    dead_block_scoreboard sb;
    bit  calm_mode;
    bit  hold_pop;
    int  sent;
    bit [63:0] pc_pool[8];
    bit [63:0] line_pool[24];

    sampling_dead_block_predictor u_top (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .address(address),
        .program_counter(program_counter), .set_sampled(set_sampled),
        .sampler_index(sampler_index), .empty(empty), .pop(pop), .prediction(prediction),
        .sampler_hit(sampler_hit), .psel(psel), .penable(penable), .pwrite(pwrite),
        .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #50_000_000;
        $display("sampling_dead_block_predictor regression: fail");
        $finish;
    end

    // Result side: checks every popped transaction and stalls at random.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (pop && !empty) sb.check_result(prediction, sampler_hit);
            pop <= !hold_pop && (calm_mode || $urandom_range(99) >= 37);
        end
    end

    task automatic write_shift(input bit [5:0] value);
        @(posedge clk);
        psel <= 1;
        penable <= 0;
        pwrite <= 1;
        paddr <= REG_TAG_SHIFT;
        pwdata <= {26'd0, value};
        @(posedge clk);
        penable <= 1;
        do @(posedge clk); while (!pready);
        psel <= 0;
        penable <= 0;
        pwrite <= 0;
        sb.shift = value;
    endtask

    task automatic send_access(input bit [63:0] addr, input bit [63:0] pc, input bit smp,
                               input bit [4:0] sset);
        while (!calm_mode && $urandom_range(99) < 37)
        begin
            push <= 0;
            @(posedge clk);
        end
        push <= 1;
        address <= addr;
        program_counter <= pc;
        set_sampled <= smp;
        sampler_index <= sset;
        do @(posedge clk); while (full);
        sb.note_access(addr, pc, smp, sset);
        sent++;
    endtask

    task automatic drain();
        push <= 0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic random_access();
        bit [63:0] a;
        bit [63:0] pc;
        if ($urandom_range(99) < 80)
        begin
            a = line_pool[$urandom_range(23)] << sb.shift;
            a = a | ({$urandom, $urandom} & ((64'd1 << sb.shift) - 1));
            pc = pc_pool[$urandom_range(7)];
            send_access(a, pc, $urandom_range(99) < 85, 5'($urandom_range(3)));
        end
        else
            send_access({$urandom, $urandom}, {$urandom, $urandom}, 1'($urandom_range(1)),
                        5'($urandom_range(31)));
    endtask

    initial
    begin
        bit [5:0] shifts[4];
        sb = new();
        rst_n = 0;
        push = 0;
        pop = 0;
        address = '0;
        program_counter = '0;
        set_sampled = 0;
        sampler_index = '0;
        psel = 0;
        penable = 0;
        pwrite = 0;
        paddr = '0;
        pwdata = '0;
        calm_mode = 0;
        hold_pop = 0;
        sent = 0;
        foreach (pc_pool[i]) pc_pool[i] = {$urandom, $urandom};
        foreach (line_pool[i]) line_pool[i] = 64'($urandom_range(40));
        repeat (2) @(posedge clk);
        rst_n <= 1;

        // Directed: field extremes, unsampled, repeated hits, and one set overflowed.
        send_access('0, '0, 1, 0);
        send_access('0, '0, 1, 0);
        send_access('1, '1, 1, 31);
        send_access('1, '1, 0, 31);
        send_access(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 1, 5'h15);
        send_access(64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555, 1, 5'h0A);
        for (int i = 0; i < 18; i++)
            send_access(64'(i) << 17, 64'h40, 1, 7);
        send_access(64'd0, 64'h40, 1, 7);
        drain();

        shifts[0] = 6'd0;
        shifts[1] = 6'd63;
        shifts[2] = 6'd6;
        shifts[3] = TAG_SHIFT_RESET;
        for (int ph = 0; ph < 4; ph++)
        begin
            write_shift(shifts[ph]);
            calm_mode = (ph == 2);
            for (int i = 0; i < 180; i++)
            begin
                if (ph == 1 && i == 20)
                    fork
                        begin
                            hold_pop = 1;
                            repeat (300) @(posedge clk);
                            hold_pop = 0;
                        end
                    join_none
                random_access();
            end
            drain();
        end
        calm_mode = 0;

        $display("Covered %0d transactions (%0d checked, %0d sampler hits) over 4 tag shifts.",
                 sent, sb.checked, sb.hits);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("sampling_dead_block_predictor regression: pass");
        else
            $display("sampling_dead_block_predictor regression: fail");
        $finish;
    end
endmodule
